@@ src/osk_pkg.sv @@
// ----------------------------------------------------------------------------
// osk_pkg
// shared sizes, codes and types of the order sorted key table
// ----------------------------------------------------------------------------
`default_nettype none

package osk_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 32;

  localparam int ORDER_W = 32;
  localparam int POS_W   = 9;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W   = $clog2(TABLE_DEPTH);

  // first-hit search is split into groups; the per-group and the across-group levels are each registered
  localparam int GROUP_SIZE = 16;
  localparam int LOC_W      = $clog2(GROUP_SIZE);
  localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                ins_en;
    logic                lookup;
    logic [ORDER_W-1:0]  order;
    logic [KEY_BITS-1:0] key;
  } cell_cmd_t;

  // result of the first-hit search
  typedef struct packed {
    logic             valid;
    logic             any;
    logic [IDX_W-1:0] idx;
  } enc_res_t;

endpackage

`default_nettype wire

@@ src/order_sorted_key_table_core.sv @@
// ----------------------------------------------------------------------------
// order_sorted_key_table_core
// insertion-sorted (order, key) table with parallel key lookup
// ----------------------------------------------------------------------------
// input beats arrive on the s_ group: tuser is the kind (insert or lookup),
// tdata carries the order value and the entry key. every beat gives exactly
// one result beat on the m_ group: position, found and overflow flags.
// the table is a chain of cells, one per slot; on insert every cell compares
// its order with the new one, cells behind the insertion point take their
// left neighbor's entry and the cell at the point takes the new entry, all
// at the same edge. lookups compare every stored key at once.
// the lowest hit is then found by a two-level registered search, so one
// item is handled at a time: the result passes the hit flags, the group
// register, the search result and the hold register, and the next beat is
// taken once it moves into the output register. a finished result waits
// there while the next beat is already taken, so a stalled receiver holds
// only that one result and blocks new beats only while a second result is ready.
// reset empties the table (entry count to zero); slot contents are left as
// they are and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module order_sorted_key_table_core
  import osk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] order_value, [63:32] entry_key
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // [8:0] position, [9] found, [10] overflow
);

  // control
  logic busy;
  logic req_valid;        // cells act in this cycle
  logic enc_start;        // cell hit flags are registered
  logic res_hold;         // search result waits for the output register
  logic s_accept;
  logic m_load;

  // latched item
  logic                kind;
  logic                full;
  logic [ORDER_W-1:0]  item_order;
  logic [KEY_BITS-1:0] item_key;
  logic [31:0]         in_key;

  logic [CNT_W-1:0] count;

  // chain of cells
  cell_cmd_t               cmd;
  logic [TABLE_DEPTH-1:0]  occ;
  logic [TABLE_DEPTH-1:0]  le;
  logic [TABLE_DEPTH-1:0]  hits;
  logic [ORDER_W-1:0]      c_order [TABLE_DEPTH];
  logic [KEY_BITS-1:0]     c_key   [TABLE_DEPTH];

  enc_res_t         enc_res;
  logic             hold_any;
  logic [IDX_W-1:0] hold_idx;

  logic [POS_W-1:0] out_pos;
  logic             out_found;
  logic             out_ovf;

  assign s_tready = !busy;
  assign s_accept = s_tvalid && s_tready;
  assign m_load   = res_hold && (!m_tvalid || m_tready);
  assign in_key   = s_tdata[63:32];

  assign cmd.ins_en = req_valid && (kind == KIND_INSERT) && !full;
  assign cmd.lookup = (kind == KIND_LOOKUP);
  assign cmd.order  = item_order;
  assign cmd.key    = item_key;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    // a slot is occupied when it lies below the entry count
    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      osk_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occ        (occ[i]),
        .prev_le    (1'b1),
        .prev_order ('0),
        .prev_key   ('0),
        .le         (le[i]),
        .order      (c_order[i]),
        .key        (c_key[i]),
        .hit        (hits[i])
      );
    end else begin : g_body
      osk_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occ        (occ[i]),
        .prev_le    (le[i-1]),
        .prev_order (c_order[i-1]),
        .prev_key   (c_key[i-1]),
        .le         (le[i]),
        .order      (c_order[i]),
        .key        (c_key[i]),
        .hit        (hits[i])
      );
    end
  end

  osk_encoder u_encoder (
    .clk   (clk),
    .rst   (rst),
    .start (enc_start),
    .hits  (hits),
    .res   (enc_res)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (s_accept) begin
      kind       <= s_tuser;
      item_order <= s_tdata[31:0];
      item_key   <= KEY_BITS'(in_key);
      full       <= (count == CNT_W'(TABLE_DEPTH));
    end
  end

  // control and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      req_valid <= 1'b0;
      enc_start <= 1'b0;
      res_hold  <= 1'b0;
      count     <= '0;
    end else begin
      req_valid <= s_accept;
      enc_start <= req_valid;
      if (s_accept) begin
        busy <= 1'b1;
      end else if (m_load) begin
        busy <= 1'b0;
      end
      if (enc_res.valid) begin
        res_hold <= 1'b1;
      end else if (m_load) begin
        res_hold <= 1'b0;
      end
      if (cmd.ins_en) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enc_res.valid) begin
      hold_any <= enc_res.any;
      hold_idx <= enc_res.idx;
    end
  end

  // result fields; the count is stable until the next beat is taken
  always_comb begin
    out_ovf   = (kind == KIND_INSERT) && full;
    out_found = hold_any && !out_ovf;
    if (hold_any && !out_ovf) begin
      out_pos = POS_W'(hold_idx);
    end else begin
      out_pos = POS_W'(count);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (m_load) begin
      m_tdata <= {5'd0, out_ovf, out_found, out_pos};
    end
  end

endmodule

`default_nettype wire

@@ src/osk_cell.sv @@
// ----------------------------------------------------------------------------
// osk_cell
// one table slot: compares against the broadcast item, shifts from its left
// ----------------------------------------------------------------------------
`default_nettype none

module osk_cell
  import osk_pkg::*;
(
  input  wire logic                clk,
  input  wire cell_cmd_t           cmd,
  input  wire logic                occ,
  input  wire logic                prev_le,
  input  wire logic [ORDER_W-1:0]  prev_order,
  input  wire logic [KEY_BITS-1:0] prev_key,
  output logic                     le,
  output logic [ORDER_W-1:0]       order,
  output logic [KEY_BITS-1:0]      key,
  output logic                     hit
);

  logic ins_here;
  logic shift;
  logic match;

  // stored prefix of order <= new order ends at the insertion point
  assign le       = occ && (order <= cmd.order);
  assign ins_here = !le && prev_le;
  assign shift    = !prev_le;
  assign match    = occ && (key == cmd.key);

  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      if (shift) begin
        order <= prev_order;
        key   <= prev_key;
      end else if (ins_here) begin
        order <= cmd.order;
        key   <= cmd.key;
      end
    end
    hit <= cmd.lookup ? match : !le;
  end

endmodule

`default_nettype wire

@@ src/osk_encoder.sv @@
// ----------------------------------------------------------------------------
// osk_encoder
// two-level registered search for the lowest set bit of the cell hit flags
// ----------------------------------------------------------------------------
`default_nettype none

module osk_encoder
  import osk_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [TABLE_DEPTH-1:0] hits,
  output enc_res_t                    res
);

  logic [PAD_DEPTH-1:0]  hit_pad;
  logic [NUM_GROUPS-1:0] g_any_next;
  logic [LOC_W-1:0]      g_loc_next [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] g_any;
  logic [LOC_W-1:0]      g_loc [NUM_GROUPS];
  logic                  s1_valid;
  logic                  any_next;
  logic [GRP_W-1:0]      grp_next;
  logic [GRP_W+LOC_W-1:0] full_idx;

  always_comb begin
    hit_pad = '0;
    hit_pad[TABLE_DEPTH-1:0] = hits;
  end

  // level one: per-group any flag and lowest local index
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      g_any_next[g] = |hit_pad[g*GROUP_SIZE +: GROUP_SIZE];
      g_loc_next[g] = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
        if (hit_pad[g*GROUP_SIZE + b]) begin
          g_loc_next[g] = LOC_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      g_any <= g_any_next;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        g_loc[g] <= g_loc_next[g];
      end
    end
  end

  // level two: lowest group with a hit
  always_comb begin
    any_next = |g_any;
    grp_next = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        grp_next = GRP_W'(g);
      end
    end
    full_idx = {grp_next, g_loc[grp_next]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      s1_valid  <= start;
      res.valid <= s1_valid;
    end
    if (s1_valid) begin
      res.any <= any_next;
      res.idx <= full_idx[IDX_W-1:0];
    end
  end

endmodule

`default_nettype wire
